// ===== src/ssrch_pkg.sv =====
// Shared constants, types and helpers for the substring search core.
// No dependencies.
package ssrch_pkg;

  localparam int MaxPattern = 16;
  localparam int MaxText    = 4096;

  localparam int PAT_LEN_W  = $clog2(MaxPattern + 1);
  localparam int TEXT_CNT_W = $clog2(MaxText + 1);
  localparam int POS_W      = 12;

  typedef logic [1:0] func_t;
  typedef logic [7:0] char_t;

  localparam func_t FUNC_PATTERN = 2'd0;
  localparam func_t FUNC_TEXT    = 2'd1;
  localparam func_t FUNC_END     = 2'd2;
  localparam func_t FUNC_CLEAR   = 2'd3;

  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_UP_A  = 8'h41;
  localparam char_t CHAR_UP_Z  = 8'h5a;
  localparam char_t CASE_DELTA = 8'h20;

  // Fold ASCII upper case to lower case when enabled.
  function automatic char_t fold_char(input char_t c, input logic ic);
    if (ic && c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

// ===== src/substring_search_core.sv =====
// Substring search core: pattern store, sliding text window, match compare.
// Depends on ssrch_pkg.
//
// An end-of-text item is captured in the input register when it is accepted
// and its result is loaded into the result register as it leaves the input
// register. Throughput: one item per cycle; an end-of-text item waits in the
// input register only while the result register holds an untaken result.
// Reset clears all control state, the text window and the case-folding
// register; the pattern store is not cleared.
module substring_search_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ssrch_pkg::func_t                func,
  input  ssrch_pkg::char_t                data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [ssrch_pkg::POS_W-1:0]     position,
  output logic                            pattern_too_long
);
  import ssrch_pkg::*;

  // Configuration
  logic ignore_case;

  // Input register
  logic  s1_valid;
  func_t s1_func;
  char_t s1_byte;
  logic  s1_go;

  // Pattern is held right-aligned: the newest byte sits in the top entry,
  // so entry j lines up with window entry j for every pattern length.
  char_t                 pattern_store [MaxPattern];
  logic [PAT_LEN_W-1:0]  pattern_length;
  logic                  pattern_ended;
  logic                  overflow_flag;

  char_t                 text_window [MaxPattern];
  char_t                 window_next [MaxPattern];
  logic [TEXT_CNT_W-1:0] text_count;
  logic [TEXT_CNT_W-1:0] text_count_next;
  logic                  text_ended;
  logic                  match_seen;
  logic [POS_W-1:0]      match_offset;

  logic [MaxPattern-1:0] hit;
  logic                  window_hit;
  logic                  text_take;
  logic                  text_room;

  // An item leaves the input register unless it is an end of text that
  // would overwrite a result still waiting at the output.
  assign s1_go    = s1_valid && (s1_func != FUNC_END || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b0;
    end else if (cfg_wr_en) begin
      ignore_case <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func;
      s1_byte <= data_byte;
    end
  end

  // Window after shifting in the current byte, and its compare against the
  // stored pattern. Entries below the aligned pattern start always match.
  always_comb begin
    logic [PAT_LEN_W:0] reach;
    for (int j = 0; j < MaxPattern - 1; j++) begin
      window_next[j] = text_window[j+1];
    end
    window_next[MaxPattern-1] = s1_byte;
    for (int j = 0; j < MaxPattern; j++) begin
      reach  = (PAT_LEN_W+1)'(j) + {1'b0, pattern_length};
      hit[j] = (reach < (PAT_LEN_W+1)'(MaxPattern)) ||
               (fold_char(window_next[j], ignore_case) ==
                fold_char(pattern_store[j], ignore_case));
    end
  end

  assign window_hit      = &hit;
  assign text_room       = text_count < TEXT_CNT_W'(MaxText);
  assign text_take       = !text_ended && s1_byte != CHAR_NUL && text_room;
  assign text_count_next = text_count + TEXT_CNT_W'(1);

  // Pattern store: shift in a new byte at the top; no reset needed since
  // only entries covered by pattern_length are ever compared.
  always_ff @(posedge clk) begin
    if (s1_go && s1_func == FUNC_PATTERN && !pattern_ended &&
        s1_byte != CHAR_NUL && pattern_length < PAT_LEN_W'(MaxPattern)) begin
      for (int j = 0; j < MaxPattern - 1; j++) begin
        pattern_store[j] <= pattern_store[j+1];
      end
      pattern_store[MaxPattern-1] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_ended  <= 1'b0;
      overflow_flag  <= 1'b0;
      text_count     <= '0;
      text_ended     <= 1'b0;
      match_seen     <= 1'b0;
      match_offset   <= '0;
      for (int j = 0; j < MaxPattern; j++) begin
        text_window[j] <= CHAR_NUL;
      end
    end else if (s1_go) begin
      unique case (s1_func)
        FUNC_PATTERN: begin
          if (!pattern_ended) begin
            if (s1_byte == CHAR_NUL) begin
              pattern_ended <= 1'b1;
            end else if (pattern_length < PAT_LEN_W'(MaxPattern)) begin
              pattern_length <= pattern_length + PAT_LEN_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
        end
        FUNC_TEXT: begin
          if (!text_ended && s1_byte == CHAR_NUL) begin
            text_ended <= 1'b1;
          end else if (text_take) begin
            for (int j = 0; j < MaxPattern; j++) begin
              text_window[j] <= window_next[j];
            end
            text_count <= text_count_next;
            // Record the first match only.
            if (!match_seen && !overflow_flag && pattern_length != '0 &&
                text_count_next >= TEXT_CNT_W'(pattern_length) && window_hit) begin
              match_seen   <= 1'b1;
              match_offset <= POS_W'(text_count_next - TEXT_CNT_W'(pattern_length));
            end
          end
        end
        FUNC_CLEAR: begin
          pattern_length <= '0;
          pattern_ended  <= 1'b0;
          overflow_flag  <= 1'b0;
          text_count     <= '0;
          text_ended     <= 1'b0;
          match_seen     <= 1'b0;
          match_offset   <= '0;
          for (int j = 0; j < MaxPattern; j++) begin
            text_window[j] <= CHAR_NUL;
          end
        end
        default: begin
          // End of text: drop the text state, keep the pattern.
          text_count   <= '0;
          text_ended   <= 1'b0;
          match_seen   <= 1'b0;
          match_offset <= '0;
          for (int j = 0; j < MaxPattern; j++) begin
            text_window[j] <= CHAR_NUL;
          end
        end
      endcase
    end
  end

  // Result register: load on end of text, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_func == FUNC_END) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_func == FUNC_END) begin
      pattern_too_long <= overflow_flag;
      if (overflow_flag) begin
        found    <= 1'b0;
        position <= '0;
      end else if (pattern_length == '0) begin
        // Empty pattern matches at the start of any text.
        found    <= 1'b1;
        position <= '0;
      end else begin
        found    <= match_seen;
        position <= match_seen ? match_offset : '0;
      end
    end
  end

endmodule

// ===== verif/substring_search_core_tb.sv =====
// Self-checking testbench for substring_search_core: drives pattern, text,
// end and clear items, predicts each search result and checks it.
// Depends on ssrch_pkg and the substring_search_core RTL.
module substring_search_core_tb;
  import ssrch_pkg::*;

  typedef struct packed {
    func_t op;
    char_t chr;
  } search_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic             too_long;
  } search_hit_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  func_t            func = FUNC_PATTERN;
  char_t            data_byte = CHAR_NUL;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             found;
  logic [POS_W-1:0] position;
  logic             pattern_too_long;

  substring_search_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found            (found),
    .position         (position),
    .pattern_too_long (pattern_too_long)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Items waiting for the driver, and search results waiting for the DUT.
  search_item_t pending_items[$];
  search_hit_t  expected_hits[$];

  int n_pushed    = 0;
  int ends_pushed = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int mismatches  = 0;
  int n_phases    = 0;

  // ---------------------------------------------------------------------
  // Search predictor: its own copy of the pattern store, the text window
  // and the case-fold setting.
  // ---------------------------------------------------------------------
  bit    fold_on = 1'b0;
  char_t pat_store[MaxPattern] = '{default: CHAR_NUL};
  int    pat_len = 0;
  bit    pat_ended = 1'b0;
  bit    pat_overflow = 1'b0;
  char_t win[MaxPattern] = '{default: CHAR_NUL};
  int    txt_count = 0;
  bit    txt_ended = 1'b0;
  bit    match_seen = 1'b0;
  int    match_off = 0;

  // Fold ASCII upper case down when case-insensitive mode is on.
  function automatic char_t lower_if(input char_t c);
    if (fold_on && c >= "A" && c <= "Z") begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic void clear_text();
    win        = '{default: CHAR_NUL};
    txt_count  = 0;
    txt_ended  = 1'b0;
    match_seen = 1'b0;
    match_off  = 0;
  endfunction

  function automatic void search_step(input func_t op, input char_t c);
    int          base;
    bit          ok;
    search_hit_t hit;
    case (op)
      FUNC_PATTERN: begin
        // Drop pattern bytes once the pattern is terminated; flag overflow.
        if (!pat_ended) begin
          if (c == CHAR_NUL) begin
            pat_ended = 1'b1;
          end else if (pat_len < MaxPattern) begin
            pat_store[pat_len] = c;
            pat_len++;
          end else begin
            pat_overflow = 1'b1;
          end
        end
      end
      FUNC_TEXT: begin
        if (!txt_ended) begin
          if (c == CHAR_NUL) begin
            txt_ended = 1'b1;
          end else if (txt_count < MaxText) begin
            // Shift the window and compare its tail with the whole pattern.
            for (int i = 0; i < MaxPattern - 1; i++) win[i] = win[i + 1];
            win[MaxPattern - 1] = c;
            txt_count++;
            if (!match_seen && !pat_overflow && pat_len > 0 && txt_count >= pat_len) begin
              base = MaxPattern - pat_len;
              ok   = 1'b1;
              for (int i = 0; i < pat_len; i++) begin
                if (lower_if(win[base + i]) != lower_if(pat_store[i])) ok = 1'b0;
              end
              if (ok) begin
                match_seen = 1'b1;
                match_off  = txt_count - pat_len;
              end
            end
          end
        end
      end
      FUNC_CLEAR: begin
        pat_len      = 0;
        pat_ended    = 1'b0;
        pat_overflow = 1'b0;
        clear_text();
      end
      FUNC_END: begin
        hit.found    = 1'b0;
        hit.pos      = '0;
        hit.too_long = pat_overflow;
        if (!pat_overflow) begin
          if (pat_len == 0) begin
            hit.found = 1'b1;
          end else if (match_seen) begin
            hit.found = 1'b1;
            hit.pos   = match_off[POS_W-1:0];
          end
        end
        expected_hits.push_back(hit);
        clear_text();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feed items at the falling edge, in bursts with random gaps.
  // ---------------------------------------------------------------------
  logic         in_took = 1'b0;
  search_item_t cur_item;
  int           burst_left = 1;
  int           gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      // The held item is gone (or none was held): pick the next one.
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_valid  <= 1'b1;
        func      <= cur_item.op;
        data_byte <= cur_item.chr;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Start a new burst; about a third of bursts run back to back.
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: cycle through always-ready, coin-flip, sparse and mostly-ready.
  int rx_cycle = 0;

  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 50) % 4)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= (rx_cycle % 9 == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on accepted items, check accepted results in order.
  // ---------------------------------------------------------------------
  search_hit_t want;

  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        search_step(func, data_byte);
        n_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: found %0b position %0d too_long %0b",
                     found, position, pattern_too_long);
          end
        end else begin
          want = expected_hits.pop_front();
          n_checked++;
          if (found !== want.found || position !== want.pos ||
              pattern_too_long !== want.too_long) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch: expected found %0b pos %0d too_long %0b,",
                       n_checked, want.found, want.pos, want.too_long);
              $display("  got found %0b pos %0d too_long %0b",
                       found, position, pattern_too_long);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_item(input func_t op, input char_t c);
    search_item_t it;
    it.op  = op;
    it.chr = c;
    pending_items.push_back(it);
    n_pushed++;
    if (op == FUNC_END) ends_pushed++;
  endfunction

  // Mostly a small alphabet around the fold boundaries so matches happen.
  function automatic char_t pick_char();
    string letters = "aAbBzZ@`[{";
    if ($urandom_range(0, 7) == 0) begin
      return char_t'($urandom_range(1, 255));
    end
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  // Hold until every pushed item is taken and every result checked, then
  // let the two-stage pipeline drain. Sample at the falling edge, where the
  // monitor's counters are settled.
  task automatic wait_idle();
    while (n_accepted != n_pushed || expected_hits.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_fold(input bit v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    fold_on = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_phases++;
  endtask

  // One random search: mostly a fresh pattern and a text that embeds it,
  // sometimes a kept pattern, an overflowing or empty one, or pure noise.
  task automatic gen_search();
    char_t pat[$];
    char_t txt[$];
    int    kind;
    int    plen;
    int    at;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      push_item(func_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      push_item(FUNC_CLEAR, char_t'($urandom_range(0, 255)));
      if (kind < 13) plen = $urandom_range(MaxPattern + 1, MaxPattern + 4);
      else if (kind < 20) plen = 0;
      else if (kind < 27) plen = MaxPattern;
      else plen = $urandom_range(1, 5);
      repeat (plen) pat.push_back(pick_char());
      foreach (pat[i]) push_item(FUNC_PATTERN, pat[i]);
      // Usually terminate; now and then send a byte the block must drop.
      if ($urandom_range(0, 9) != 0) begin
        push_item(FUNC_PATTERN, CHAR_NUL);
        if ($urandom_range(0, 9) == 0) push_item(FUNC_PATTERN, pick_char());
      end
    end
    repeat ($urandom_range(0, 20)) txt.push_back(pick_char());
    // Embed zero to two copies, flipping bit 5 of some letters.
    if (pat.size() != 0) begin
      repeat ($urandom_range(0, 2)) begin
        at = $urandom_range(0, txt.size());
        for (int j = 0; j < pat.size(); j++) begin
          txt.insert(at + j, (pat[j][6] && $urandom_range(0, 1)) ? pat[j] ^ 8'h20 : pat[j]);
        end
      end
    end
    foreach (txt[i]) begin
      if ($urandom_range(0, 29) == 0) push_item(FUNC_PATTERN, pick_char());
      push_item(FUNC_TEXT, txt[i]);
    end
    if ($urandom_range(0, 6) == 0) begin
      push_item(FUNC_TEXT, CHAR_NUL);
      repeat ($urandom_range(0, 3)) push_item(FUNC_TEXT, pick_char());
    end
    push_item(FUNC_END, char_t'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  int phase_items;
  int phase_ends;

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: case-sensitive, extremes of bytes, every operation.
    set_fold(1'b0);
    @(posedge clk);
    push_item(FUNC_END, CHAR_NUL);             // empty pattern, empty text
    push_item(FUNC_PATTERN, "a");
    push_item(FUNC_PATTERN, 8'hff);
    push_item(FUNC_PATTERN, CHAR_NUL);
    push_item(FUNC_PATTERN, "z");              // after terminator: drop
    push_item(FUNC_TEXT, "a");
    push_item(FUNC_TEXT, "A");
    push_item(FUNC_TEXT, "a");
    push_item(FUNC_TEXT, 8'hff);
    push_item(FUNC_TEXT, CHAR_NUL);
    push_item(FUNC_TEXT, "a");                 // after text terminator: drop
    push_item(FUNC_END, 8'hff);
    push_item(FUNC_CLEAR, 8'hff);
    push_item(FUNC_PATTERN, "B");
    push_item(FUNC_TEXT, "b");
    push_item(FUNC_PATTERN, "c");              // grow the pattern mid-text
    push_item(FUNC_TEXT, "B");
    push_item(FUNC_TEXT, "c");
    push_item(FUNC_END, CHAR_NUL);
    push_item(FUNC_PATTERN, CHAR_NUL);
    push_item(FUNC_TEXT, 8'h80);
    push_item(FUNC_END, CHAR_NUL);
    push_item(FUNC_CLEAR, CHAR_NUL);
    push_item(FUNC_END, CHAR_NUL);             // empty pattern after clear
    wait_idle();

    // Random searches over alternating fold settings.
    for (int p = 0; p < 4; p++) begin
      set_fold(p % 2 == 0);
      @(posedge clk);
      phase_items = n_pushed;
      phase_ends  = ends_pushed;
      while (n_pushed - phase_items < 200 || ends_pushed - phase_ends < 8) gen_search();
      wait_idle();
    end

    $display("run covered %0d items and %0d checked results over %0d config phases,",
             n_accepted, n_checked, n_phases);
    $display("both fold settings, empty and overflowing patterns, and dropped bytes");
    if (mismatches == 0) begin
      $display("substring_search_core_tb: done, clean");
    end else begin
      $display("substring_search_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("timeout: %0d of %0d items taken, %0d results outstanding",
             n_accepted, n_pushed, expected_hits.size());
    $display("substring_search_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssrch_pkg.sv
src/substring_search_core.sv
verif/substring_search_core_tb.sv
